>>> hdl/wrmg_pkg.sv
// ----------------------------------------------------------------------------
// Wind rotation matrix generator package
// Shared widths, constant tables and fixed-point helpers.
// ----------------------------------------------------------------------------
package wrmg_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned StrW   = 16;
  localparam int unsigned EntryW = 16;
  localparam int unsigned CordW  = 34;
  localparam int unsigned WideW  = 35;
  localparam int unsigned CordSteps = 16;

  localparam logic [TimeW-1:0]  AngleScale = 32'd417566265;
  localparam logic [CordW-1:0]  CordX0     = 34'sd652032874;

  localparam logic [1:0] QuadI   = 2'd0;
  localparam logic [1:0] QuadII  = 2'd1;
  localparam logic [1:0] QuadIII = 2'd2;

  typedef logic signed [EntryW-1:0] entry_t;

  function automatic logic [TimeW-1:0] freq_k(input logic [1:0] m, input logic f);
    logic [TimeW-1:0] k;
    case ({m, f})
      3'b000:  k = 32'd2050695827;
      3'b001:  k = 32'd2324121937;
      3'b010:  k = 32'd3417826378;
      3'b011:  k = 32'd2050695827;
      3'b100:  k = 32'd2597548047;
      3'b101:  k = 32'd683565276;
      3'b110:  k = 32'd2050695827;
      default: k = 32'd3007687213;
    endcase
    return k;
  endfunction

  function automatic logic signed [CordW-1:0] atan_turn(input logic [3:0] i);
    logic [31:0] a;
    case (i)
      4'd0:    a = 32'h20000000;
      4'd1:    a = 32'h12E4051E;
      4'd2:    a = 32'h09FB385B;
      4'd3:    a = 32'h051111D4;
      4'd4:    a = 32'h028B0D43;
      4'd5:    a = 32'h0145D7E1;
      4'd6:    a = 32'h00A2F61E;
      4'd7:    a = 32'h00517C55;
      4'd8:    a = 32'h0028BE53;
      4'd9:    a = 32'h00145F2F;
      4'd10:   a = 32'h000A2F98;
      4'd11:   a = 32'h000517CC;
      4'd12:   a = 32'h00028BE6;
      4'd13:   a = 32'h000145F3;
      4'd14:   a = 32'h0000A2FA;
      default: a = 32'h0000517D;
    endcase
    return $signed({2'b00, a});
  endfunction

  // round Q2.30 (or a Q2.30-scaled product) to Q1.15 with saturation
  function automatic entry_t to_q15(input logic signed [WideW-1:0] v);
    logic signed [WideW:0] t;
    logic signed [WideW-15:0] s;
    entry_t r;
    t = $signed({v[WideW-1], v}) + $signed((WideW+1)'(16384));
    s = $signed(t[WideW:15]);
    if (s > $signed((WideW-14)'(32767)))       r = 16'sh7FFF;
    else if (s < -$signed((WideW-14)'(32768))) r = 16'sh8000;
    else                                        r = s[EntryW-1:0];
    return r;
  endfunction

  function automatic entry_t q_neg(input entry_t a);
    return (a == 16'sh8000) ? 16'sh7FFF : -a;
  endfunction

endpackage

>>> hdl/wrmg_cordic.sv
// ----------------------------------------------------------------------------
// Wind rotation matrix generator CORDIC
// Iterative rotation CORDIC, one micro-rotation per cycle, quadrant folded.
// ----------------------------------------------------------------------------
module wrmg_cordic (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [31:0]          angle_i,
  output logic                 done_o,
  output wrmg_pkg::entry_t     cos_o,
  output wrmg_pkg::entry_t     sin_o
);
  import wrmg_pkg::*;

  logic signed [CordW-1:0] x_q, y_q, z_q;
  logic [1:0]              quad_q;
  logic [3:0]              step_q;
  logic                    busy_q, done_q;
  logic signed [CordW-1:0] xs, ys;
  logic signed [WideW-1:0] xw, yw, c, s;

  assign xs = x_q >>> step_q;
  assign ys = y_q >>> step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      quad_q <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        x_q    <= CordX0;
        y_q    <= '0;
        z_q    <= $signed({4'b0000, angle_i[29:0]});
        quad_q <= angle_i[31:30];
        step_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (!z_q[CordW-1]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_turn(step_q);
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_turn(step_q);
        end
        step_q <= step_q + 4'd1;
        if (step_q == 4'(CordSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign xw = {x_q[CordW-1], x_q};
  assign yw = {y_q[CordW-1], y_q};

  always_comb begin
    case (quad_q)
      QuadI:   begin c = xw;  s = yw;  end
      QuadII:  begin c = -yw; s = xw;  end
      QuadIII: begin c = -xw; s = -yw; end
      default: begin c = yw;  s = -xw; end
    endcase
  end

  assign done_o = done_q;
  assign cos_o  = to_q15(c);
  assign sin_o  = to_q15(s);

endmodule

>>> hdl/wind_rotation_matrix_generator_core.sv
// ----------------------------------------------------------------------------
// Wind rotation matrix generator core
// Per time stamp, advance the matrix clocks, rescale them at non-zero strength
// and emit one rotation matrix per matrix clock, built on a shared multiplier,
// divider and CORDIC.
// Sequence: per matrix, the clock is advanced, rescaled at non-zero strength
//   by the bit-serial divider, then four CORDIC runs and four products follow.
// Throughput: one time stamp per NUM_MATRICES matrices; the input is not
//   ready while a stamp is in work, and output stalls hold the sequence.
// Reset: clocks, previous time and strength clear; the first stamp uses the
//   current strength as the old one.
// ----------------------------------------------------------------------------
module wind_rotation_matrix_generator_core #(
  parameter int unsigned NUM_MATRICES = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [31:0]   s_axis_tdata_i,   // time_secs
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // matrix_index, entry_cos_y, entry_neg_sin_y, entry_sx_sy, entry_cos_x,
  // entry_sx_cy, entry_sy_cx, entry_neg_sin_x, entry_cx_cy, zero pad
  output logic [135:0]  m_axis_tdata_o,
  output logic          m_axis_tlast_o,   // last_of_run
  input  logic          psel_i,
  input  logic          penable_i,
  input  logic          pwrite_i,
  input  logic [2:0]    paddr_i,
  input  logic [31:0]   pwdata_i,
  output logic [31:0]   prdata_o,
  output logic          pready_o
);
  import wrmg_pkg::*;

  localparam int unsigned IdxW = (NUM_MATRICES > 1) ? $clog2(NUM_MATRICES) : 1;
  localparam logic [2:0] AddrStrength = 3'd0;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ADD, ST_MUL_OLD, ST_DIV_LOAD, ST_DIV, ST_DIV_END,
    ST_P, ST_PH_LO, ST_PH_HI, ST_PH_SUM, ST_CORD,
    ST_ANG_A, ST_ANG_B, ST_ANG_C, ST_QM, ST_QS, ST_OUT
  } state_e;

  state_e               state_q;
  logic [StrW-1:0]      strength_q, prev_str_q, old_q;
  logic [TimeW-1:0]     prev_time_q, delta_q;
  logic                 first_done_q;
  logic [TimeW-1:0]     clk_q [NUM_MATRICES];
  logic [1:0]           idx_q, trig_q, qi_q;
  logic                 fsel_q;
  logic signed [65:0]   prod_q;
  logic [59:0]          acc_q;
  logic [15:0]          phi_q;
  logic [47:0]          dvd_q;
  logic [16:0]          rem_q;
  logic [5:0]           cnt_q;
  entry_t               xp_q, yp_q, cx_q, sx_q, cy_q, sy_q;
  entry_t               qr_q [4];
  logic                 ov_q;
  logic [135:0]         od_q;
  logic                 ol_q;

  logic signed [32:0]   mul_a, mul_b;
  logic [TimeW-1:0]     clk_cur;
  entry_t               pct;
  logic [16:0]          pct_mag;
  logic [16:0]          rem_try;
  logic [59:0]          ph_sum;
  logic [31:0]          ang_mag;
  logic                 cord_start, cord_done;
  logic [31:0]          cord_angle;
  entry_t               cord_cos, cord_sin;
  logic                 cfg_wr;

  assign clk_cur = clk_q[idx_q[IdxW-1:0]];
  assign pct     = (trig_q == 2'd1) ? xp_q : yp_q;
  assign pct_mag = pct[EntryW-1] ? -{pct[EntryW-1], pct} : {pct[EntryW-1], pct};
  assign rem_try = {rem_q[15:0], dvd_q[47]};
  assign ph_sum  = acc_q + {prod_q[27:0], 32'd0};
  assign ang_mag = prod_q[58:27];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_OLD: begin
        mul_a = $signed({1'b0, clk_cur});
        mul_b = $signed({17'd0, old_q});
      end
      ST_P: begin
        mul_a = $signed({1'b0, clk_cur});
        mul_b = $signed({17'd0, strength_q});
      end
      ST_PH_LO: begin
        mul_a = $signed({1'b0, prod_q[31:0]});
        mul_b = $signed({1'b0, freq_k(idx_q, fsel_q)});
      end
      ST_PH_HI: begin
        mul_a = $signed({17'd0, phi_q});
        mul_b = $signed({1'b0, freq_k(idx_q, fsel_q)});
      end
      ST_ANG_A: begin
        mul_a = $signed({17'd0, strength_q});
        mul_b = $signed({16'd0, pct_mag});
      end
      ST_ANG_B: begin
        mul_a = $signed({1'b0, prod_q[31:0]});
        mul_b = $signed({1'b0, AngleScale});
      end
      ST_QM: begin
        case (qi_q)
          2'd0:    begin mul_a = 33'(sx_q); mul_b = 33'(sy_q); end
          2'd1:    begin mul_a = 33'(sx_q); mul_b = 33'(cy_q); end
          2'd2:    begin mul_a = 33'(sy_q); mul_b = 33'(cx_q); end
          default: begin mul_a = 33'(cx_q); mul_b = 33'(cy_q); end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    cord_start = 1'b0;
    cord_angle = '0;
    if (state_q == ST_PH_SUM) begin
      cord_start = 1'b1;
      cord_angle = ph_sum[59:28];
    end else if (state_q == ST_ANG_C) begin
      cord_start = 1'b1;
      cord_angle = pct[EntryW-1] ? (32'd0 - ang_mag) : ang_mag;
    end
  end

  wrmg_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .angle_i (cord_angle),
    .done_o  (cord_done),
    .cos_o   (cord_cos),
    .sin_o   (cord_sin)
  );

  assign cfg_wr = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      strength_q   <= '0;
      prev_str_q   <= '0;
      old_q        <= '0;
      prev_time_q  <= '0;
      delta_q      <= '0;
      first_done_q <= 1'b0;
      for (int i = 0; i < NUM_MATRICES; i++) clk_q[i] <= '0;
      idx_q  <= '0;
      trig_q <= '0;
      qi_q   <= '0;
      fsel_q <= 1'b0;
      prod_q <= '0;
      acc_q  <= '0;
      phi_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      xp_q <= '0; yp_q <= '0; cx_q <= '0; sx_q <= '0; cy_q <= '0; sy_q <= '0;
      for (int i = 0; i < 4; i++) qr_q[i] <= '0;
      ov_q <= 1'b0;
      od_q <= '0;
      ol_q <= 1'b0;
    end else begin
      prod_q <= mul_a * mul_b;
      if (cfg_wr && paddr_i == AddrStrength) strength_q <= pwdata_i[StrW-1:0];
      if (ov_q && m_axis_tready_i && state_q != ST_OUT) ov_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            delta_q      <= s_axis_tdata_i - prev_time_q;
            old_q        <= first_done_q ? prev_str_q : strength_q;
            prev_time_q  <= s_axis_tdata_i;
            prev_str_q   <= strength_q;
            first_done_q <= 1'b1;
            idx_q        <= '0;
            state_q      <= ST_ADD;
          end
        end
        ST_ADD: begin
          clk_q[idx_q[IdxW-1:0]] <= clk_cur + delta_q;
          fsel_q  <= 1'b0;
          state_q <= (strength_q != '0) ? ST_MUL_OLD : ST_P;
        end
        ST_MUL_OLD: state_q <= ST_DIV_LOAD;
        ST_DIV_LOAD: begin
          dvd_q   <= prod_q[47:0];
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (rem_try >= {1'b0, strength_q}) begin
            rem_q <= rem_try - {1'b0, strength_q};
            dvd_q <= {dvd_q[46:0], 1'b1};
          end else begin
            rem_q <= rem_try;
            dvd_q <= {dvd_q[46:0], 1'b0};
          end
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd47) state_q <= ST_DIV_END;
        end
        ST_DIV_END: begin
          clk_q[idx_q[IdxW-1:0]] <= (dvd_q[47:32] != '0) ? '1 : dvd_q[31:0];
          state_q <= ST_P;
        end
        ST_P: state_q <= ST_PH_LO;
        ST_PH_LO: begin
          phi_q   <= prod_q[47:32];
          state_q <= ST_PH_HI;
        end
        ST_PH_HI: begin
          acc_q   <= prod_q[59:0];
          state_q <= ST_PH_SUM;
        end
        ST_PH_SUM: begin
          trig_q  <= {1'b0, fsel_q};
          state_q <= ST_CORD;
        end
        ST_CORD: begin
          if (cord_done) begin
            case (trig_q)
              2'd0: begin
                xp_q    <= cord_sin;
                fsel_q  <= 1'b1;
                state_q <= ST_P;
              end
              2'd1: begin
                yp_q    <= cord_cos;
                state_q <= ST_ANG_A;
              end
              2'd2: begin
                cx_q    <= cord_cos;
                sx_q    <= cord_sin;
                state_q <= ST_ANG_A;
              end
              default: begin
                cy_q    <= cord_cos;
                sy_q    <= cord_sin;
                qi_q    <= '0;
                state_q <= ST_QM;
              end
            endcase
          end
        end
        ST_ANG_A: state_q <= ST_ANG_B;
        ST_ANG_B: state_q <= ST_ANG_C;
        ST_ANG_C: begin
          trig_q  <= trig_q + 2'd1;
          state_q <= ST_CORD;
        end
        ST_QM: state_q <= ST_QS;
        ST_QS: begin
          qr_q[qi_q] <= to_q15($signed(prod_q[WideW-1:0]));
          qi_q       <= qi_q + 2'd1;
          state_q    <= (qi_q == 2'd3) ? ST_OUT : ST_QM;
        end
        ST_OUT: begin
          if (!ov_q || m_axis_tready_i) begin
            ov_q <= 1'b1;
            od_q <= {6'd0, qr_q[3], q_neg(sx_q), qr_q[2], qr_q[1], cx_q,
                     qr_q[0], q_neg(sy_q), cy_q, idx_q};
            ol_q <= (32'(idx_q) == NUM_MATRICES - 1);
            if (32'(idx_q) == NUM_MATRICES - 1) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= ST_ADD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;
  assign m_axis_tlast_o  = ol_q;
  assign pready_o        = 1'b1;
  assign prdata_o        = (paddr_i == AddrStrength) ? {16'd0, strength_q} : 32'd0;

endmodule
